### rtl/iiee_pkg.sv
// ----------------------------------------------------------------------------
// iiee_pkg
// Shared types, codes and the microcode table of the infix expression evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package iiee_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int KIND_W         = 3;
    localparam int UPC_W          = 4;

    // operator that follows the operand
    typedef enum logic [KIND_W-1:0] {
        KIND_PLUS   = 3'd0,
        KIND_MINUS  = 3'd1,
        KIND_TIMES  = 3'd2,
        KIND_DIVIDE = 3'd3,
        KIND_EQUALS = 3'd4
    } kind_t;

    // pending multiplicative operator
    typedef enum logic [1:0] {
        MUL_NONE   = 2'd0,
        MUL_TIMES  = 2'd1,
        MUL_DIVIDE = 2'd2
    } mulop_t;

    // datapath operation of one microcode step
    typedef enum logic [3:0] {
        UOP_NOP      = 4'd0,
        UOP_LOAD     = 4'd1,
        UOP_DIV_INIT = 4'd2,
        UOP_DIV_STEP = 4'd3,
        UOP_DIV_FIX  = 4'd4,
        UOP_MUL_INIT = 4'd5,
        UOP_MUL_STEP = 4'd6,
        UOP_MUL_FIX  = 4'd7,
        UOP_SET_ERR  = 4'd8,
        UOP_SET_TERM = 4'd9,
        UOP_APPLY_OP = 4'd10,
        UOP_EMIT     = 4'd11
    } uop_t;

    // jump condition of one microcode step
    typedef enum logic [3:0] {
        COND_NEVER       = 4'd0,
        COND_ALWAYS      = 4'd1,
        COND_NO_ITEM     = 4'd2,
        COND_MUL_NONE    = 4'd3,
        COND_MUL_TIMES   = 4'd4,
        COND_X_ZERO      = 4'd5,
        COND_CNT_MORE    = 4'd6,
        COND_KIND_NOT_EQ = 4'd7,
        COND_OUT_BUSY    = 4'd8
    } cond_t;

    typedef logic [UPC_W-1:0] upc_t;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        upc_t  target;
    } ctrl_word_t;

    // microcode addresses
    localparam upc_t UA_FETCH    = 4'd0;
    localparam upc_t UA_BR_NONE  = 4'd1;
    localparam upc_t UA_BR_TIMES = 4'd2;
    localparam upc_t UA_BR_ZERO  = 4'd3;
    localparam upc_t UA_DIV_INIT = 4'd4;
    localparam upc_t UA_DIV_STEP = 4'd5;
    localparam upc_t UA_DIV_FIX  = 4'd6;
    localparam upc_t UA_MUL_INIT = 4'd7;
    localparam upc_t UA_MUL_STEP = 4'd8;
    localparam upc_t UA_MUL_FIX  = 4'd9;
    localparam upc_t UA_DIV_ZERO = 4'd10;
    localparam upc_t UA_SET_TERM = 4'd11;
    localparam upc_t UA_APPLY_OP = 4'd12;
    localparam upc_t UA_EMIT     = 4'd13;
    localparam upc_t UA_RETURN   = 4'd14;

    // control store: jump to target when the condition holds, else fall through
    function automatic ctrl_word_t ucode_rom(input upc_t addr);
        ctrl_word_t cw;
        unique case (addr)
            UA_FETCH:    cw = '{UOP_LOAD,     COND_NO_ITEM,     UA_FETCH};
            UA_BR_NONE:  cw = '{UOP_NOP,      COND_MUL_NONE,    UA_SET_TERM};
            UA_BR_TIMES: cw = '{UOP_NOP,      COND_MUL_TIMES,   UA_MUL_INIT};
            UA_BR_ZERO:  cw = '{UOP_NOP,      COND_X_ZERO,      UA_DIV_ZERO};
            UA_DIV_INIT: cw = '{UOP_DIV_INIT, COND_NEVER,       UA_FETCH};
            UA_DIV_STEP: cw = '{UOP_DIV_STEP, COND_CNT_MORE,    UA_DIV_STEP};
            UA_DIV_FIX:  cw = '{UOP_DIV_FIX,  COND_ALWAYS,      UA_APPLY_OP};
            UA_MUL_INIT: cw = '{UOP_MUL_INIT, COND_NEVER,       UA_FETCH};
            UA_MUL_STEP: cw = '{UOP_MUL_STEP, COND_CNT_MORE,    UA_MUL_STEP};
            UA_MUL_FIX:  cw = '{UOP_MUL_FIX,  COND_ALWAYS,      UA_APPLY_OP};
            UA_DIV_ZERO: cw = '{UOP_SET_ERR,  COND_ALWAYS,      UA_APPLY_OP};
            UA_SET_TERM: cw = '{UOP_SET_TERM, COND_NEVER,       UA_FETCH};
            UA_APPLY_OP: cw = '{UOP_APPLY_OP, COND_KIND_NOT_EQ, UA_FETCH};
            UA_EMIT:     cw = '{UOP_EMIT,     COND_OUT_BUSY,    UA_EMIT};
            UA_RETURN:   cw = '{UOP_NOP,      COND_ALWAYS,      UA_FETCH};
            default:     cw = '{UOP_NOP,      COND_ALWAYS,      UA_FETCH};
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

### rtl/iiee_in_if.sv
// ----------------------------------------------------------------------------
// iiee_in_if
// Token channel: signed operand and the operator after it, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface iiee_in_if #(
    parameter int DATA_WIDTH = iiee_pkg::DATA_WIDTH_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic signed [DATA_WIDTH-1:0]   operand;
    logic [iiee_pkg::KIND_W-1:0]    kind;

    modport source (output valid, output operand, output kind, input ready);
    modport sink (input valid, input operand, input kind, output ready);
    modport monitor (input valid, input operand, input kind, input ready);
endinterface

`default_nettype wire

### rtl/iiee_out_if.sv
// ----------------------------------------------------------------------------
// iiee_out_if
// Result channel: expression value and division-by-zero flag, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface iiee_out_if #(
    parameter int DATA_WIDTH = iiee_pkg::DATA_WIDTH_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic signed [DATA_WIDTH-1:0]   total;
    logic                           div_by_zero;

    modport source (output valid, output total, output div_by_zero, input ready);
    modport sink (input valid, input total, input div_by_zero, output ready);
    modport monitor (input valid, input total, input div_by_zero, input ready);
endinterface

`default_nettype wire

### rtl/infix_integer_expression_evaluator.sv
// ----------------------------------------------------------------------------
// infix_integer_expression_evaluator
// Four-function infix calculator with precedence, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// usage
//   cmd carries one token pair per transfer: an operand and the operator after
//   it (plus, minus, times, divide, equals). res carries one transfer per
//   equals: the expression value and a sticky division-by-zero flag.
//   cmd.ready is high only while the sequencer sits at its fetch step, so
//   one token is in work at a time.
//   per token: an operand with no pending times/divide just becomes the term;
//   a pending times runs a shift-add multiply (1 bit/cycle), a pending divide
//   a restoring divide (1 bit/cycle) that a zero divisor skips; equals then
//   runs the emit step, where the result is registered into res.
//   both loops run on the shared shift/add datapath.
//   operator codes 5 to 7 are taken at the fetch step and dropped.
//   res is a single output register: it holds while res.ready is low, and
//   the sequencer waits at its emit step only if a new result meets a full one.
//   reset clears the total, term, pending operators and the error flag, and
//   starts the sequencer at fetch with res empty.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_integer_expression_evaluator #(
    parameter int DATA_WIDTH = iiee_pkg::DATA_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    iiee_in_if.sink    cmd,
    iiee_out_if.source res
);
    import iiee_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH);

    // sequencer
    upc_t       upc_reg, upc_next;
    ctrl_word_t cw;
    logic       take_jump;

    // architectural state
    logic [DATA_WIDTH-1:0] total_reg, total_next;
    logic [DATA_WIDTH-1:0] term_reg, term_next;
    mulop_t                mulop_reg, mulop_next;
    logic                  sign_reg, sign_next;
    logic                  err_reg, err_next;

    // captured token
    logic [DATA_WIDTH-1:0] opnd_reg, opnd_next;
    logic [KIND_W-1:0]     kind_reg, kind_next;

    // shared shift/add datapath: rem is remainder or product accumulator,
    // quo is quotient or multiplier, aux is divisor or multiplicand
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [DATA_WIDTH-1:0] aux_reg, aux_next;
    logic                  neg_reg, neg_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] out_total_reg, out_total_next;
    logic                  out_dz_reg, out_dz_next;

    logic                  accept;
    logic                  kind_ok;
    logic                  out_busy;
    logic [DATA_WIDTH:0]   div_shift;
    logic [DATA_WIDTH:0]   div_trial;

    assign cw        = ucode_rom(upc_reg);
    assign cmd.ready = (upc_reg == UA_FETCH);
    assign accept    = cmd.valid && cmd.ready;
    assign kind_ok   = (cmd.kind <= KIND_EQUALS);
    assign out_busy  = out_valid_reg && !res.ready;

    assign res.valid       = out_valid_reg;
    assign res.total       = out_total_reg;
    assign res.div_by_zero = out_dz_reg;

    // one restoring division step
    assign div_shift = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign div_trial = div_shift - {1'b0, aux_reg};

    // jump condition
    always_comb
    begin
        case (cw.cond)
            COND_NEVER:       take_jump = 1'b0;
            COND_ALWAYS:      take_jump = 1'b1;
            COND_NO_ITEM:     take_jump = !cmd.valid || !kind_ok;
            COND_MUL_NONE:    take_jump = (mulop_reg == MUL_NONE);
            COND_MUL_TIMES:   take_jump = (mulop_reg == MUL_TIMES);
            COND_X_ZERO:      take_jump = (opnd_reg == '0);
            COND_CNT_MORE:    take_jump = (cnt_reg != '0);
            COND_KIND_NOT_EQ: take_jump = (kind_reg != KIND_EQUALS);
            COND_OUT_BUSY:    take_jump = out_busy;
            default:          take_jump = 1'b1;
        endcase
    end

    assign upc_next = take_jump ? cw.target : upc_t'(upc_reg + 1'b1);

    // datapath driven by the control word
    always_comb
    begin
        total_next     = total_reg;
        term_next      = term_reg;
        mulop_next     = mulop_reg;
        sign_next      = sign_reg;
        err_next       = err_reg;
        opnd_next      = opnd_reg;
        kind_next      = kind_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        aux_next       = aux_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_total_next = out_total_reg;
        out_dz_next    = out_dz_reg;

        unique case (cw.uop)
            UOP_NOP:
            begin
            end
            UOP_LOAD:
            begin
                if (accept)
                begin
                    opnd_next = cmd.operand;
                    kind_next = cmd.kind;
                end
            end
            UOP_DIV_INIT:
            begin
                // divide magnitudes, sign fixed at the end
                quo_next = term_reg[DATA_WIDTH-1] ? (~term_reg + 1'b1) : term_reg;
                aux_next = opnd_reg[DATA_WIDTH-1] ? (~opnd_reg + 1'b1) : opnd_reg;
                rem_next = '0;
                neg_next = term_reg[DATA_WIDTH-1] ^ opnd_reg[DATA_WIDTH-1];
                cnt_next = CNT_W'(DATA_WIDTH - 1);
            end
            UOP_DIV_STEP:
            begin
                if (!div_trial[DATA_WIDTH])
                begin
                    rem_next = div_trial[DATA_WIDTH-1:0];
                    quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    rem_next = div_shift[DATA_WIDTH-1:0];
                    quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end
            UOP_DIV_FIX:
            begin
                term_next = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
            end
            UOP_MUL_INIT:
            begin
                rem_next = '0;
                aux_next = term_reg;
                quo_next = opnd_reg;
                cnt_next = CNT_W'(DATA_WIDTH - 1);
            end
            UOP_MUL_STEP:
            begin
                if (quo_reg[0])
                begin
                    rem_next = rem_reg + aux_reg;
                end
                aux_next = {aux_reg[DATA_WIDTH-2:0], 1'b0};
                quo_next = {1'b0, quo_reg[DATA_WIDTH-1:1]};
                cnt_next = cnt_reg - 1'b1;
            end
            UOP_MUL_FIX:
            begin
                term_next = rem_reg;
            end
            UOP_SET_ERR:
            begin
                err_next = 1'b1;
            end
            UOP_SET_TERM:
            begin
                term_next = opnd_reg;
            end
            UOP_APPLY_OP:
            begin
                case (kind_reg)
                    KIND_TIMES:  mulop_next = MUL_TIMES;
                    KIND_DIVIDE: mulop_next = MUL_DIVIDE;
                    default:
                    begin
                        // finished term folds into the total
                        total_next = sign_reg ? (total_reg - term_reg)
                                              : (total_reg + term_reg);
                        term_next  = '0;
                        mulop_next = MUL_NONE;
                        if (kind_reg == KIND_PLUS)
                        begin
                            sign_next = 1'b0;
                        end
                        else if (kind_reg == KIND_MINUS)
                        begin
                            sign_next = 1'b1;
                        end
                    end
                endcase
            end
            UOP_EMIT:
            begin
                if (!out_busy)
                begin
                    out_valid_next = 1'b1;
                    out_total_next = total_reg;
                    out_dz_next    = err_reg;
                    total_next     = '0;
                    sign_next      = 1'b0;
                    err_next       = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= UA_FETCH;
            total_reg     <= '0;
            term_reg      <= '0;
            mulop_reg     <= MUL_NONE;
            sign_reg      <= 1'b0;
            err_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            total_reg     <= total_next;
            term_reg      <= term_next;
            mulop_reg     <= mulop_next;
            sign_reg      <= sign_next;
            err_reg       <= err_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        opnd_reg      <= opnd_next;
        kind_reg      <= kind_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        aux_reg       <= aux_next;
        neg_reg       <= neg_next;
        out_total_reg <= out_total_next;
        out_dz_reg    <= out_dz_next;
    end

endmodule

`default_nettype wire

### rtl/iiee_checker.sv
// ----------------------------------------------------------------------------
// iiee_checker
// Port-level assertions for the expression evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module iiee_checker #(
    parameter int DATA_WIDTH = iiee_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    input  wire logic                        cmd_ready,
    input  wire logic [iiee_pkg::KIND_W-1:0] cmd_kind,
    input  wire logic                        res_valid,
    input  wire logic                        res_ready,
    input  wire logic [DATA_WIDTH-1:0]       res_total,
    input  wire logic                        res_div_by_zero
);
    import iiee_pkg::*;

    logic valid_kind;

    assign valid_kind = (cmd_kind == KIND_PLUS) || (cmd_kind == KIND_MINUS)
                     || (cmd_kind == KIND_TIMES) || (cmd_kind == KIND_DIVIDE)
                     || (cmd_kind == KIND_EQUALS);

    // stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // stalled result payload holds
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_total) && $stable(res_div_by_zero))
        else $error("result payload changed while stalled");

    // a real token leaves the sequencer busy in the next cycle
    a_busy_after_token: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && valid_kind |=> !cmd_ready)
        else $error("token channel ready right after a token transfer");

    // a new result only comes out of the emit step, never at fetch
    a_emit_not_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> !cmd_ready)
        else $error("result appeared while waiting for a token");

endmodule

bind infix_integer_expression_evaluator iiee_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_iiee_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .cmd_kind        (cmd.kind),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_total       (res.total),
    .res_div_by_zero (res.div_by_zero)
);

`default_nettype wire

### dv/expression_value_checker.sv
// ----------------------------------------------------------------------------
// expression_value_checker
// Watches the token and result channels, evaluates each expression with its
// own precedence model and compares every result transfer in order.
// ----------------------------------------------------------------------------
module expression_value_checker #(
    parameter int DATA_WIDTH = iiee_pkg::DATA_WIDTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    iiee_in_if.monitor  cmd,
    iiee_out_if.monitor res,
    output int          fail_count,
    output int          results_owed
);
    import iiee_pkg::*;

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef struct packed {
        word_t total;
        logic  div_by_zero;
    } expr_result_t;

    expr_result_t totals_due[$];

    word_t  sum_acc;
    word_t  term_acc;
    mulop_t mul_pending;
    logic   minus_pending;
    logic   dbz_seen;
    int     mismatches;

    // signed division that truncates toward zero; most negative / -1 wraps
    function automatic word_t quotient_toward_zero(input word_t num, input word_t den);
        logic [DATA_WIDTH:0] num_ext;
        logic [DATA_WIDTH:0] den_ext;
        logic [DATA_WIDTH:0] num_mag;
        logic [DATA_WIDTH:0] den_mag;
        logic [DATA_WIDTH:0] quo;
        num_ext = {num[DATA_WIDTH-1], num};
        den_ext = {den[DATA_WIDTH-1], den};
        num_mag = num_ext[DATA_WIDTH] ? -num_ext : num_ext;
        den_mag = den_ext[DATA_WIDTH] ? -den_ext : den_ext;
        quo = num_mag / den_mag;
        if (num[DATA_WIDTH-1] != den[DATA_WIDTH-1])
            quo = -quo;
        return quo[DATA_WIDTH-1:0];
    endfunction

    // advance the expression state by one token, queue a total on equals
    task automatic fold_token(input word_t x, input logic [KIND_W-1:0] op);
        expr_result_t due;
        if (op > KIND_EQUALS)
            return;
        case (mul_pending)
            MUL_TIMES:
                term_acc = term_acc * x;
            MUL_DIVIDE:
                if (x == '0)
                    dbz_seen = 1'b1;
                else
                    term_acc = quotient_toward_zero(term_acc, x);
            default:
                term_acc = x;
        endcase
        if (op == KIND_TIMES)
        begin
            mul_pending = MUL_TIMES;
            return;
        end
        if (op == KIND_DIVIDE)
        begin
            mul_pending = MUL_DIVIDE;
            return;
        end
        sum_acc = minus_pending ? sum_acc - term_acc : sum_acc + term_acc;
        term_acc = '0;
        mul_pending = MUL_NONE;
        minus_pending = (op == KIND_MINUS);
        if (op == KIND_EQUALS)
        begin
            due.total = sum_acc;
            due.div_by_zero = dbz_seen;
            totals_due.push_back(due);
            sum_acc = '0;
            dbz_seen = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        expr_result_t due;
        if (!rst_n)
        begin
            sum_acc = '0;
            term_acc = '0;
            mul_pending = MUL_NONE;
            minus_pending = 1'b0;
            dbz_seen = 1'b0;
            mismatches = 0;
            totals_due.delete();
        end
        else
        begin
            if (cmd.valid && cmd.ready)
                fold_token(cmd.operand, cmd.kind);
            if (res.valid && res.ready)
            begin
                if (totals_due.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual total %0d flag %0b",
                             $time, res.total, res.div_by_zero);
                    mismatches++;
                end
                else
                begin
                    due = totals_due.pop_front();
                    if (res.total !== due.total)
                    begin
                        $display("%0t: total mismatch: expected %0d, actual %0d",
                                 $time, $signed(due.total), res.total);
                        mismatches++;
                    end
                    if (res.div_by_zero !== due.div_by_zero)
                    begin
                        $display("%0t: div_by_zero mismatch: expected %0b, actual %0b",
                                 $time, due.div_by_zero, res.div_by_zero);
                        mismatches++;
                    end
                end
            end
        end
        fail_count <= mismatches;
        results_owed <= totals_due.size();
    end

endmodule

### dv/tb_infix_integer_expression_evaluator.sv
// ----------------------------------------------------------------------------
// tb_infix_integer_expression_evaluator
// Feeds directed and random token streams to the evaluator with bursty input
// and a stalling result side; a checker beside the block predicts each total.
// ----------------------------------------------------------------------------
module tb_infix_integer_expression_evaluator;
    import iiee_pkg::*;

    localparam int DATA_WIDTH   = DATA_WIDTH_DEF;
    // stop the random part once this many live tokens have gone in
    localparam int TOKEN_GOAL   = 1750;
    // hard stop bound, with wide room for slow divide tokens, gaps and stalls
    localparam int CYCLE_LIMIT  = 600000;
    // longest token plus the emit step, with margin
    localparam int DRAIN_CYCLES = 120;

    // operator codes the block must drop without a trace
    localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_MID   = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

    typedef logic [DATA_WIDTH-1:0] word_t;

    localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam word_t WORD_ONE = word_t'(1);
    localparam word_t WORD_NEG = '1;

    // result-side behavior, changed after stretches of random length
    typedef enum logic [1:0] {
        SINK_FREE,
        SINK_COIN,
        SINK_TRICKLE
    } sink_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    iiee_in_if  #(.DATA_WIDTH(DATA_WIDTH)) cmd ();
    iiee_out_if #(.DATA_WIDTH(DATA_WIDTH)) res ();

    int         fail_count;
    int         results_owed;
    int         cycle_count = 0;
    int         tokens_sent = 0;
    int         burst_left  = 1;
    int         sink_phase_left = 0;
    sink_mode_t sink_mode = SINK_FREE;

    infix_integer_expression_evaluator #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    expression_value_checker #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .res          (res),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    always #5 clk = ~clk;

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: free-running, coin-flip and trickle stretches of random length
    always @(posedge clk)
    begin
        if (sink_phase_left == 0)
        begin
            sink_mode <= sink_mode_t'($urandom_range(2, 0));
            sink_phase_left <= $urandom_range(300, 20);
        end
        else
        begin
            sink_phase_left <= sink_phase_left - 1;
        end
        case (sink_mode)
            SINK_FREE:    res.ready <= 1'b1;
            SINK_COIN:    res.ready <= 1'($urandom_range(1, 0));
            default:      res.ready <= ($urandom_range(7, 0) == 0);
        endcase
    end

    // one token transfer, then the sender's burst/gap pacing
    task automatic push_token(input word_t value, input logic [KIND_W-1:0] op);
        int gap;
        cmd.valid   <= 1'b1;
        cmd.operand <= value;
        cmd.kind    <= op;
        do
            @(posedge clk);
        while (!cmd.ready);
        if (op <= KIND_EQUALS)
            tokens_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            // now and then a long stretch with no idle cycles at all
            if ($urandom_range(5, 0) == 0)
                burst_left = $urandom_range(200, 50);
            else
                burst_left = $urandom_range(12, 1);
            gap = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 8) : $urandom_range(6, 0);
            if (gap > 0)
            begin
                cmd.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // mix of zero, corner values, small values (useful quotients) and full-range noise
    function automatic word_t pick_operand();
        case ($urandom_range(7, 0))
            0: return '0;
            1:
                case ($urandom_range(3, 0))
                    0: return WORD_MAX;
                    1: return WORD_MIN;
                    2: return WORD_NEG;
                    default: return WORD_ONE;
                endcase
            2, 3, 4: return word_t'($signed($urandom_range(200, 0)) - 100);
            default: return word_t'($urandom);
        endcase
    endfunction

    // one well-formed expression of random length, closed by equals,
    // with an occasional dropped operator code slipped in
    task automatic run_expression();
        int n_tokens;
        int i;
        logic [KIND_W-1:0] op;
        n_tokens = ($urandom_range(3, 0) == 0) ? $urandom_range(10, 5) : $urandom_range(4, 1);
        for (i = 0; i < n_tokens; i++)
        begin
            if ($urandom_range(11, 0) == 0)
                push_token(word_t'($urandom),
                           KIND_W'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST)));
            if (i == n_tokens - 1)
                op = KIND_EQUALS;
            else
                op = KIND_W'($urandom_range(KIND_DIVIDE, KIND_PLUS));
            push_token(pick_operand(), op);
        end
    endtask

    initial
    begin
        cmd.valid   <= 1'b0;
        cmd.operand <= '0;
        cmd.kind    <= KIND_PLUS;

        // single reset at the start of the run
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sum overflow: max + 1 wraps to the most negative value
        push_token(WORD_MAX, KIND_PLUS);
        push_token(WORD_ONE, KIND_EQUALS);
        // most negative / -1 wraps back to the most negative value
        push_token(WORD_MIN, KIND_DIVIDE);
        push_token(WORD_NEG, KIND_EQUALS);
        // divide by zero keeps the term and raises the sticky flag
        push_token(word_t'(7), KIND_DIVIDE);
        push_token('0, KIND_TIMES);
        push_token(word_t'(3), KIND_EQUALS);
        // flag cleared by the equals; -7 / 2 truncates toward zero
        push_token(word_t'(5), KIND_MINUS);
        push_token(word_t'(-7), KIND_DIVIDE);
        push_token(word_t'(2), KIND_EQUALS);
        // product overflow and subtraction of the most negative value
        push_token(WORD_MAX, KIND_TIMES);
        push_token(WORD_MAX, KIND_MINUS);
        push_token(WORD_MIN, KIND_EQUALS);
        // unused operator codes are dropped, even mid-expression
        push_token(word_t'(123), KIND_UNUSED_FIRST);
        push_token(word_t'(9), KIND_TIMES);
        push_token(WORD_NEG, KIND_UNUSED_MID);
        push_token(word_t'(4), KIND_EQUALS);
        push_token(WORD_MAX, KIND_UNUSED_LAST);
        // bare equals, and min * -1
        push_token('0, KIND_EQUALS);
        push_token(WORD_MIN, KIND_TIMES);
        push_token(WORD_NEG, KIND_EQUALS);

        while (tokens_sent < TOKEN_GOAL)
            run_expression();

        cmd.valid <= 1'b0;
        // let the checker count the last transfer before reading its backlog
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && results_owed == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### infix_integer_expression_evaluator.f
rtl/iiee_pkg.sv
rtl/iiee_in_if.sv
rtl/iiee_out_if.sv
rtl/infix_integer_expression_evaluator.sv
rtl/iiee_checker.sv
dv/expression_value_checker.sv
dv/tb_infix_integer_expression_evaluator.sv
